### rtl/swg_pkg.sv
`timescale 1ns / 1ps
package swg_pkg;
  localparam int WINDOW_MAX_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CFG_W = 7;
endpackage

### rtl/sliding_window_gcd_max_unit.sv
`timescale 1ns / 1ps
// Sliding-window gcd with running maximum. Values are kept in a two-stack queue held in two
// block RAMs (push stack with prefix gcds, pop stack with suffix gcds); one binary gcd unit,
// one bit step per cycle, does all the arithmetic. An item costs two gcds (one when the
// window is not yet full) plus control states. When the pop stack runs empty, each moved
// value adds one gcd; every value is moved once.
// Items are processed one at a time; a result waits in the output register while the next
// item is taken, and a second result stalls the block until the first one is taken.
// window_size of 0 acts as 1, above WINDOW_MAX as WINDOW_MAX; first_item
// empties the window and clears best_gcd. Write window_size only while the block is idle.
module sliding_window_gcd_max_unit import swg_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       window_size,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] sample_value,
  input  logic                   first_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] window_gcd,
  output logic [VALUE_WIDTH-1:0] best_gcd
);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SW = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int VW = VALUE_WIDTH;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_CHECK     = 12'b000000000010,
    S_XFER_RD   = 12'b000000000100,
    S_XFER_WAIT = 12'b000000001000,
    S_XFER_G    = 12'b000000010000,
    S_POP       = 12'b000000100000,
    S_POP_WAIT  = 12'b000001000000,
    S_PUSH      = 12'b000010000000,
    S_PUSH_G    = 12'b000100000000,
    S_WIN       = 12'b001000000000,
    S_WIN_G     = 12'b010000000000,
    S_OUT       = 12'b100000000000
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] ws;
  logic [CNT_W-1:0] fc;
  logic [CNT_W-1:0] bc;
  logic [CNT_W-1:0] fill;
  logic [VW-1:0]    front_top;
  logic [VW-1:0]    back_top;
  logic [VW-1:0]    best;
  logic [VW-1:0]    win_res;
  logic [VW-1:0]    v;

  logic [SW-1:0]    ws_ext;
  logic [SW-1:0]    eff;
  logic [SW-1:0]    fill_ext;
  logic [SW-1:0]    fill_inc_ext;
  logic [CNT_W-1:0] fc_m1;
  logic [CNT_W-1:0] bc_m2;

  logic             f_we;
  logic [AW-1:0]    f_waddr;
  logic [2*VW-1:0]  f_wdata;
  logic [AW-1:0]    f_raddr;
  logic [2*VW-1:0]  f_rdata;
  logic             b_we;
  logic [AW-1:0]    b_waddr;
  logic [VW-1:0]    b_wdata;
  logic [AW-1:0]    b_raddr;
  logic [VW-1:0]    b_rdata;

  logic             g_start;
  logic [VW-1:0]    g_a;
  logic [VW-1:0]    g_b;
  logic             g_done;
  logic [VW-1:0]    g_res;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);

  assign ws_ext = SW'(ws);
  always_comb begin
    eff = ws_ext;
    if (ws_ext == '0) begin
      eff = SW'(1);
    end else if (ws_ext > SW'(WINDOW_MAX)) begin
      eff = SW'(WINDOW_MAX);
    end
  end
  assign fill_ext = SW'(fill);
  assign fill_inc_ext = SW'(fill) + SW'(1);
  assign fc_m1 = fc - CNT_W'(1);
  assign bc_m2 = bc - CNT_W'(2);

  assign f_raddr = fc_m1[AW-1:0];
  assign f_waddr = fc[AW-1:0];
  assign f_wdata = {v, g_res};
  assign f_we = (state == S_PUSH_G) && g_done;
  assign b_raddr = bc_m2[AW-1:0];
  assign b_waddr = bc[AW-1:0];
  assign b_wdata = g_res;
  assign b_we = (state == S_XFER_G) && g_done;

  always_comb begin
    g_start = 1'b0;
    g_a = front_top;
    g_b = back_top;
    unique case (state)
      S_XFER_WAIT: begin
        g_start = 1'b1;
        g_a = f_rdata[2*VW-1:VW];
      end
      S_PUSH: begin
        g_start = 1'b1;
        g_a = v;
        g_b = front_top;
      end
      S_WIN: begin
        g_start = 1'b1;
      end
      default: begin
        g_start = 1'b0;
      end
    endcase
  end

  swg_ram #(.WIDTH(2 * VW), .DEPTH(WINDOW_MAX), .AW(AW)) u_front (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  swg_ram #(.WIDTH(VW), .DEPTH(WINDOW_MAX), .AW(AW)) u_back (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  swg_gcd #(.VALUE_WIDTH(VW)) u_gcd (
    .clk(clk), .rst(rst), .start(g_start), .a_in(g_a), .b_in(g_b),
    .done(g_done), .result(g_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ws <= CFG_W'(1);
      fc <= '0;
      bc <= '0;
      fill <= '0;
      front_top <= '0;
      back_top <= '0;
      best <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ws <= window_size;
      end
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            v <= sample_value;
            if (first_item) begin
              fc <= '0;
              bc <= '0;
              fill <= '0;
              front_top <= '0;
              back_top <= '0;
              best <= '0;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (fill_ext >= eff && fill != '0) begin
            state <= (bc == '0) ? S_XFER_RD : S_POP;
          end else begin
            state <= S_PUSH;
          end
        end
        S_XFER_RD: begin
          state <= S_XFER_WAIT;
        end
        S_XFER_WAIT: begin
          state <= S_XFER_G;
        end
        S_XFER_G: begin
          if (g_done) begin
            back_top <= g_res;
            bc <= bc + CNT_W'(1);
            fc <= fc_m1;
            if (fc == CNT_W'(1)) begin
              front_top <= '0;
              state <= S_POP;
            end else begin
              state <= S_XFER_RD;
            end
          end
        end
        S_POP: begin
          bc <= bc - CNT_W'(1);
          fill <= fill - CNT_W'(1);
          if (bc >= CNT_W'(2)) begin
            state <= S_POP_WAIT;
          end else begin
            back_top <= '0;
            state <= S_CHECK;
          end
        end
        S_POP_WAIT: begin
          back_top <= b_rdata;
          state <= S_CHECK;
        end
        S_PUSH: begin
          state <= S_PUSH_G;
        end
        S_PUSH_G: begin
          if (g_done) begin
            front_top <= g_res;
            fc <= fc + CNT_W'(1);
            fill <= fill + CNT_W'(1);
            state <= (fill_inc_ext < eff) ? S_IDLE : S_WIN;
          end
        end
        S_WIN: begin
          state <= S_WIN_G;
        end
        S_WIN_G: begin
          if (g_done) begin
            win_res <= g_res;
            if (g_res > best) begin
              best <= g_res;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            window_gcd <= win_res;
            best_gcd <= best;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_sum: assert property (@(posedge clk) disable iff (rst)
    SW'(fill) == SW'(fc) + SW'(bc))
    else $error("fill count differs from stack sizes");
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW_MAX))
    else $error("fill count above window depth");
  a_back_empty: assert property (@(posedge clk) disable iff (rst)
    (bc == '0) |-> (back_top == '0))
    else $error("empty pop stack with nonzero top gcd");
  a_gcd_done: assert property (@(posedge clk) disable iff (rst)
    g_done |-> (state == S_XFER_G || state == S_PUSH_G || state == S_WIN_G))
    else $error("gcd result outside a wait state");
`endif
endmodule

### rtl/swg_ram.sv
`timescale 1ns / 1ps
module swg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/swg_gcd.sv
`timescale 1ns / 1ps
module swg_gcd import swg_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] a_in,
  input  logic [VALUE_WIDTH-1:0] b_in,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);
  localparam int KW = $clog2(VALUE_WIDTH) + 1;

  logic                   busy;
  logic [VALUE_WIDTH-1:0] a;
  logic [VALUE_WIDTH-1:0] b;
  logic [KW-1:0]          k;
  logic [VALUE_WIDTH-1:0] diff_ab;
  logic [VALUE_WIDTH-1:0] diff_ba;

  assign diff_ab = a - b;
  assign diff_ba = b - a;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        a <= a_in;
        b <= b_in;
        k <= '0;
      end else if (busy) begin
        if (a == '0 || b == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          result <= (a | b) << k;
        end else if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + KW'(1);
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a >= b) begin
          a <= diff_ab >> 1;
        end else begin
          b <= diff_ba >> 1;
        end
      end
    end
  end
endmodule
